### hdl/crc16tc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 trailer checker: shared types and functions
// Mode codes, request type, reset polynomial and the bytewise CRC fold.
// ----------------------------------------------------------------------------
package crc16tc_pkg;

  localparam logic [15:0] POLY_RESET = 16'h9EB2;

  typedef enum logic [1:0] {
    MODE_START      = 2'd0,
    MODE_POST_START = 2'd1,
    MODE_RESTART    = 2'd2,
    MODE_PUSH       = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  data_byte;
  } req_t;

  // MSB-first fold of one byte, eight shifts unrolled
  function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                           input logic [7:0]  b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/crc16tc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 trailer checker: input register
// Holds one request; refills in the cycle it hands its request on.
// ----------------------------------------------------------------------------
module crc16tc_in_stage import crc16tc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       req_i,
  input  logic       take_i,     // downstream takes the held request
  output logic       valid_o,
  output req_t       req_o
);

  logic valid_q, valid_d;
  req_t req_q;
  logic ready;
  logic accept;

  assign ready   = !valid_q || take_i;
  assign accept  = in_valid_i && ready;
  assign valid_d = accept ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign in_stall_o = !ready;
  assign valid_o    = valid_q;
  assign req_o      = req_q;

endmodule

### hdl/crc16tc_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 trailer checker: state update
// Running CRC and byte window, with the next-state logic for one request.
// ----------------------------------------------------------------------------
module crc16tc_update import crc16tc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  req_t        req_i,
  input  logic [15:0] poly_i,
  output logic [15:0] crc_d_o,
  output logic        match_d_o,
  output logic [15:0] crc_q_o,
  output logic [15:0] win_q_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] win_q, win_d;
  logic [15:0] fold_base;

  // restart folds from a cleared CRC
  assign fold_base = (req_i.mode == MODE_RESTART) ? 16'h0000 : crc_q;

  always_comb begin
    crc_d = crc_q;
    win_d = {win_q[7:0], req_i.data_byte};
    case (req_i.mode)
      MODE_START:      win_d = {8'h00, req_i.data_byte};
      MODE_POST_START: crc_d = crc_q;
      MODE_RESTART,
      MODE_PUSH:       crc_d = crc_fold(fold_base, win_q[15:8], poly_i);
      default:         crc_d = crc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0;
      win_q <= '0;
    end else if (step_i) begin
      crc_q <= crc_d;
      win_q <= win_d;
    end
  end

  assign crc_d_o   = crc_d;
  assign match_d_o = (win_d == crc_d);
  assign crc_q_o   = crc_q;
  assign win_q_o   = win_q;

endmodule

### hdl/crc16tc_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 trailer checker: result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module crc16tc_out_stage import crc16tc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [15:0] crc_i,
  input  logic        match_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] crc_value_o,
  output logic        crc_match_o
);

  logic        valid_q, valid_d;
  logic [15:0] crc_q;
  logic        match_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      crc_q   <= crc_i;
      match_q <= match_i;
    end
  end

  assign out_valid_o = valid_q;
  assign crc_value_o = crc_q;
  assign crc_match_o = match_q;

endmodule

### hdl/crc16_trailer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 trailer checker
// Receive-side CRC-16 check of a frame whose last two bytes carry the CRC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries mode_i and data_byte_i;
//   a request is taken at a clock edge with valid high and stall low.
//   Output channel (out_valid_o / out_stall_i) gives one result per request:
//   crc_value_o and crc_match_o.
//   A taken request moves from the input register to the result register.
//   Throughput: one request per cycle unless the receiver stalls; the
//   byte fold is one combinational step between input and result registers.
//   While the receiver stalls, the result register holds and the input
//   register still takes one more request; then in_stall_o rises.
//   poly is written through cfg_we_i / cfg_wdata_i; the user must do so
//   only while idle; the block does not enforce it. Reset clears the CRC
//   and byte window, empties both registers and loads poly with 0x9EB2.
// ----------------------------------------------------------------------------
module crc16_trailer_checker import crc16tc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] crc_value_o,
  output logic        crc_match_o
);

  logic [15:0] poly_q;
  req_t        in_req;
  req_t        s1_req;
  logic        s1_valid;
  logic        out_free;
  logic        step;
  logic [15:0] crc_d;
  logic        match_d;
  logic [15:0] crc_q;
  logic [15:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= POLY_RESET;
    end else if (cfg_we_i) begin
      poly_q <= cfg_wdata_i;
    end
  end

  assign in_req = '{mode: mode_e'(mode_i), data_byte: data_byte_i};
  assign step   = s1_valid && out_free;

  crc16tc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_req),
    .take_i     (step),
    .valid_o    (s1_valid),
    .req_o      (s1_req)
  );

  crc16tc_update u_upd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .req_i     (s1_req),
    .poly_i    (poly_q),
    .crc_d_o   (crc_d),
    .match_d_o (match_d),
    .crc_q_o   (crc_q),
    .win_q_o   (win_q)
  );

  crc16tc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .crc_i       (crc_d),
    .match_i     (match_d),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o),
    .crc_match_o (crc_match_o)
  );

`ifndef SYNTHESIS
  // a freshly loaded result agrees with the state it came from
  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(step) |-> (crc_value_o == crc_q) && (crc_match_o == (win_q == crc_q)))
    else $error("result does not match updated state");

  // an empty input register never stalls the sender
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> !in_stall_o)
    else $error("stall with empty input register");

  // state moves only on a step
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(crc_q) && $stable(win_q))
    else $error("state changed without a request");
`endif

endmodule

### bench/crc16_trailer_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-16 trailer checker testbench
// Drives byte requests in all four modes and frames, intact or with one bit
// flipped, under several polynomials. Each result is checked against a local
// bit-serial CRC and window model. Sender gaps, receiver stalls and a long
// output hold-off are applied in turn.
// ----------------------------------------------------------------------------
module crc16_trailer_checker_tb;
  import crc16tc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [15:0] crc;
    logic        hit;
  } crc_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] crc_value_o;
  logic        crc_match_o;

  // local copy of the checker state
  logic [15:0] model_poly;
  logic [15:0] model_crc;
  logic [15:0] model_win;

  crc_result_t pending_results[$];
  crc_result_t head_r;
  int unsigned mismatches;
  int unsigned sent_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_len;

  crc16_trailer_checker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .crc_value_o (crc_value_o),
    .crc_match_o (crc_match_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  // bit-serial form: feedback is the CRC top bit XOR the next message bit
  function automatic logic [15:0] crc_shift_byte(logic [15:0] crc, logic [7:0] b,
                                                 logic [15:0] gen);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ gen;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t ns %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic predict_result(mode_e m, logic [7:0] b);
    crc_result_t r;
    case (m)
      MODE_START: begin
        model_win = {8'h00, b};
      end
      MODE_POST_START: begin
        model_win = {model_win[7:0], b};
      end
      default: begin
        if (m == MODE_RESTART) begin
          model_crc = '0;
        end
        model_crc = crc_shift_byte(model_crc, model_win[15:8], model_poly);
        model_win = {model_win[7:0], b};
      end
    endcase
    r.crc = model_crc;
    r.hit = (model_win == model_crc);
    pending_results.push_back(r);
  endtask

  // valid is left high after acceptance; it drops only on a gap or a drain
  task automatic send_req(mode_e m, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    predict_result(m, b);
    sent_count++;
  endtask

  task automatic send_noise();
    send_req(mode_e'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  // body, then the CRC high and low bytes; one bit flipped when corrupt is set
  task automatic send_frame(int unsigned len, bit corrupt);
    logic [7:0]  bytes_q[$];
    logic [15:0] fcs;
    mode_e       m;
    fcs = '0;
    for (int unsigned k = 0; k < len; k++) begin
      bytes_q.push_back(8'($urandom_range(255)));
      fcs = crc_shift_byte(fcs, bytes_q[k], model_poly);
    end
    bytes_q.push_back(fcs[15:8]);
    bytes_q.push_back(fcs[7:0]);
    if (corrupt) begin
      bytes_q[$urandom_range(bytes_q.size() - 1)] ^= 8'(1 << $urandom_range(7));
    end
    foreach (bytes_q[i]) begin
      m = (i == 0) ? MODE_START : (i == 1) ? MODE_POST_START :
          (i == 2) ? MODE_RESTART : MODE_PUSH;
      send_req(m, bytes_q[i]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_poly(logic [15:0] gen);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= gen;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_poly = gen;
  endtask

  task automatic mixed_traffic(int unsigned n_items);
    int unsigned base;
    int unsigned pick;
    base = sent_count;
    while (sent_count - base < n_items) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8),
                   1'b0);
      end else if (pick < 82) begin
        send_frame($urandom_range(1, 8), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    // push before any start uses the cleared window
    send_req(MODE_PUSH, 8'hFF);
    send_req(MODE_PUSH, 8'h00);
    send_req(MODE_RESTART, 8'h80);
    // start clears the window high byte
    send_req(MODE_START, 8'hFF);
    send_req(MODE_POST_START, 8'h00);
    send_req(MODE_RESTART, 8'hFF);
    send_req(MODE_PUSH, 8'h01);
    send_req(MODE_PUSH, 8'hFE);
    send_req(MODE_START, 8'h00);
    send_req(MODE_START, 8'hA5);
    send_req(MODE_POST_START, 8'h5A);
    send_req(MODE_POST_START, 8'hFF);
    send_frame(1, 1'b0);
    send_frame(3, 1'b0);
    send_frame(2, 1'b1);
    drain();
  endtask

  task automatic test_poly_extremes();
    logic [15:0] polys[6];
    polys = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h1021, POLY_RESET};
    send_idle_pct = 20;
    stall_pct     = 20;
    foreach (polys[i]) begin
      write_poly(polys[i]);
      send_frame(2, 1'b0);
      mixed_traffic(14);
      drain();
    end
  endtask

  task automatic test_idle_phases();
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 72, 0, 20};
    stall_set = '{0, 0, 72, 20};
    for (int p = 0; p < 4; p++) begin
      write_poly(16'($urandom_range(16'hFFFF)));
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      mixed_traffic(120);
      drain();
    end
  endtask

  // output held off long enough for the block to back up into its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_poly(POLY_RESET);
    hold_len = 80;
    mixed_traffic(40);
    drain();
  endtask

  // receiver side: random stalls, or one long hold when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", crc_value_o, 16'h0000);
      end else begin
        head_r = pending_results.pop_front();
        if (crc_value_o !== head_r.crc) begin
          report_mismatch("crc_value", crc_value_o, head_r.crc);
        end
        if (crc_match_o !== head_r.hit) begin
          report_mismatch("crc_match", {15'd0, crc_match_o}, {15'd0, head_r.hit});
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_START;
    data_byte_i   = '0;
    model_poly    = POLY_RESET;
    model_crc     = '0;
    model_win     = '0;
    mismatches    = 0;
    sent_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed();
    test_poly_extremes();
    test_idle_phases();
    test_backpressure();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
